// ----- hw/rtl/assert_macros.svh -----
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cond at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that ante at an edge implies cons at the same edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/psu_pkg.sv -----
package psu_pkg;

   // Row filter codes; anything above Paeth is held as FLT_BAD.
   typedef enum logic [2:0] {
      FLT_NONE  = 3'd0,
      FLT_SUB   = 3'd1,
      FLT_UP    = 3'd2,
      FLT_AVG   = 3'd3,
      FLT_PAETH = 3'd4,
      FLT_BAD   = 3'd5
   } filter_type;

   // Register indexes on the csr port.
   localparam logic [1:0] CSR_BPP      = 2'd0;
   localparam logic [1:0] CSR_ROW_LEN  = 2'd1;
   localparam logic [1:0] CSR_ROWS     = 2'd2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int BPP_W      = 4;
   localparam int ROW_LEN_W  = 14;
   localparam int ROWS_W     = 16;

   localparam logic [BPP_W-1:0]     BPP_RESET     = 4'd4;
   localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 14'd4096;
   localparam logic [ROWS_W-1:0]    ROWS_RESET    = 16'd1;

   // Queue depths between front and back, and in front of the result port.
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   // Per-byte control that the front hands to the back.
   typedef struct packed {
      filter_type filter;
      logic       first_row;
      logic       row_end;
      logic       image_end;
   } ctl_type;

   // One result word.
   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       row_end;
      logic       image_end;
      logic       bad_filter;
   } rsp_type;

   function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      logic signed [10:0] p;
      logic signed [10:0] da;
      logic signed [10:0] db;
      logic signed [10:0] dc;
      logic [10:0]        pa;
      logic [10:0]        pb;
      logic [10:0]        pc;
      p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
      da = p - $signed({3'b000, a});
      db = p - $signed({3'b000, b});
      dc = p - $signed({3'b000, c});
      pa = da[10] ? 11'(-da) : 11'(da);
      pb = db[10] ? 11'(-db) : 11'(db);
      pc = dc[10] ? 11'(-dc) : 11'(dc);
      if (pa <= pb && pa <= pc) begin
         return a;
      end else if (pb <= pc) begin
         return b;
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/png_scanline_unfilter_core.sv -----
// PNG scanline reconstruction. Feed the inflated image stream a byte per word on
// req_stream_byte: the first byte of each row is the filter code (None, Sub, Up,
// Average, Paeth), and each of the following row_bytes bytes comes back as one
// result word with the reconstructed byte and row_end / image_end marks. Filter
// bytes give no result. A code above Paeth passes the row through with
// bad_filter set. The first row of an image sees an all-zero row above it, and
// after image_rows rows the block starts over on a first row. The block takes
// one byte per clock cycle when the result side keeps up; a data byte passes the
// queue between front and back, the registered read of the prior-row memory and
// the result queue before it shows up at the result port. There is no clearing
// pass after reset. Write the csr registers (0 bytes_per_pixel, 1 row_bytes,
// 2 image_rows) only while nothing is in flight; values out of range are clamped,
// and a row below the first of an image must not reach past the bytes that the
// rows before it have written.
`include "assert_macros.svh"

module png_scanline_unfilter_core #(
   parameter int MAX_ROW_BYTES   = 8192,
   parameter int MAX_PIXEL_BYTES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // input word queue
   input  logic                             push,
   output logic                             full,
   input  logic [7:0]                       req_stream_byte,
   // result word queue
   output logic                             empty,
   input  logic                             pop,
   output logic [7:0]                       rsp_pixel_byte,
   output logic                             rsp_row_end,
   output logic                             rsp_image_end,
   output logic                             rsp_bad_filter,
   // register writes
   input  logic                             csr_wr_en,
   input  logic [psu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [psu_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import psu_pkg::*;

   localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int LEN_W  = $clog2(MAX_ROW_BYTES + 1);
   localparam int CMP_W  = (LEN_W > ROW_LEN_W) ? LEN_W : ROW_LEN_W;
   localparam int MID_W  = 8 + ADDR_W + $bits(ctl_type);
   localparam int MCW    = $clog2(MID_DEPTH + 1);
   localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_ROW_BYTES);
   localparam logic [BPP_W-1:0] MAX_BPP = BPP_W'(MAX_PIXEL_BYTES);

   logic [BPP_W-1:0]     bpp_ff;
   logic [ROW_LEN_W-1:0] row_len_ff;
   logic [ROWS_W-1:0]    rows_ff;

   logic [BPP_W-1:0]     eff_bpp;
   logic [CMP_W-1:0]     len_wide;
   logic [LEN_W-1:0]     eff_len;
   logic [ROWS_W-1:0]    eff_rows;

   logic                 take;
   logic                 mid_push, mid_pop, mid_full, mid_empty;
   logic [7:0]           item_byte;
   logic [ADDR_W-1:0]    item_col;
   ctl_type              item_ctl;
   logic [MID_W-1:0]     mid_wdata, mid_rdata;
   logic [MCW-1:0]       mid_count;
   rsp_type              rsp_word;

   // ---- registers: clamp out-of-range values on the way out ----
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff     <= BPP_RESET;
         row_len_ff <= ROW_LEN_RESET;
         rows_ff    <= ROWS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BPP:     bpp_ff     <= csr_wdata[BPP_W-1:0];
            CSR_ROW_LEN: row_len_ff <= csr_wdata[ROW_LEN_W-1:0];
            CSR_ROWS:    rows_ff    <= csr_wdata[ROWS_W-1:0];
            default:     ;  // drop writes beyond the register list
         endcase
      end
   end

   assign eff_bpp  = (bpp_ff == '0) ? BPP_W'(1) : ((bpp_ff > MAX_BPP) ? MAX_BPP : bpp_ff);
   assign len_wide = (row_len_ff == '0) ? CMP_W'(1)
                   : ((CMP_W'(row_len_ff) > MAX_LEN) ? MAX_LEN : CMP_W'(row_len_ff));
   assign eff_len  = len_wide[LEN_W-1:0];
   assign eff_rows = (rows_ff == '0) ? ROWS_W'(1) : rows_ff;

   // ---- front: split filter codes from data, track column and row ----
   assign full = mid_full;
   assign take = push && !mid_full;

   psu_front #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .stream_byte (req_stream_byte),
      .eff_len     (eff_len),
      .eff_rows    (eff_rows),
      .item_valid  (mid_push),
      .item_byte   (item_byte),
      .item_col    (item_col),
      .item_ctl    (item_ctl)
   );

   // ---- decoupling queue: column-tagged data words ----
   assign mid_wdata = {item_byte, item_col, item_ctl};

   psu_fifo #(
      .WIDTH (MID_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (mid_wdata),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .count (mid_count),
      .full  (mid_full),
      .empty (mid_empty)
   );

   // ---- back: prior-row read, predictor, add, write back, result queue ----
   psu_back #(
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (mid_empty),
      .q_byte    (mid_rdata[MID_W-1 -: 8]),
      .q_col     (mid_rdata[$bits(ctl_type) +: ADDR_W]),
      .q_ctl     (ctl_type'(mid_rdata[$bits(ctl_type)-1:0])),
      .q_pop     (mid_pop),
      .eff_bpp   (eff_bpp),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_word  (rsp_word)
   );

   assign rsp_pixel_byte = rsp_word.pixel_byte;
   assign rsp_row_end    = rsp_word.row_end;
   assign rsp_image_end  = rsp_word.image_end;
   assign rsp_bad_filter = rsp_word.bad_filter;

   // ---- checks ----
   `ASSERT_IMPLY(a_image_end_on_row_end, clock, reset, !empty && rsp_image_end, rsp_row_end, "image end without row end")
   `ASSERT_IMPLY(a_front_no_push_full, clock, reset, mid_push, !mid_full, "front pushed into a full queue")
   `ASSERT_ALWAYS(a_mid_count_bound, clock, reset, mid_count <= MCW'(MID_DEPTH), "mid queue count out of range")
   `ASSERT_IMPLY(a_pop_needs_word, clock, reset, mid_pop, !mid_empty, "back popped an empty queue")

endmodule

// ----- hw/rtl/psu_fifo.sv -----
module psu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             wdata,
   input  logic                         pop,
   output logic [WIDTH-1:0]             rdata,
   output logic [$clog2(DEPTH+1)-1:0]   count,
   output logic                         full,
   output logic                         empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- hw/rtl/psu_ram.sv -----
module psu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic                                      re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

endmodule

// ----- hw/rtl/psu_front.sv -----
module psu_front #(
   parameter int MAX_ROW_BYTES = 8192
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              take,
   input  logic [7:0]                                        stream_byte,
   input  logic [$clog2(MAX_ROW_BYTES+1)-1:0]                eff_len,
   input  logic [psu_pkg::ROWS_W-1:0]                        eff_rows,
   output logic                                              item_valid,
   output logic [7:0]                                        item_byte,
   output logic [((MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1)-1:0] item_col,
   output psu_pkg::ctl_type                                  item_ctl
);
   import psu_pkg::*;

   localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int LEN_W  = $clog2(MAX_ROW_BYTES + 1);
   localparam int CW     = (ADDR_W + 1 > LEN_W) ? ADDR_W + 1 : LEN_W;

   logic              await_ff, await_in;
   logic              first_ff, first_in;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [ROWS_W-1:0] row_ff, row_in;
   filter_type        filt_ff, filt_in;
   logic [CW-1:0]     col_next;
   logic [ROWS_W:0]   row_next;
   logic              rend, iend;

   assign col_next = CW'(col_ff) + 1'b1;
   assign row_next = {1'b0, row_ff} + 1'b1;
   assign rend     = (col_next >= CW'(eff_len));
   assign iend     = rend && (row_next >= {1'b0, eff_rows});

   assign item_valid         = take && !await_ff;
   assign item_byte          = stream_byte;
   assign item_col           = col_ff;
   assign item_ctl.filter    = filt_ff;
   assign item_ctl.first_row = first_ff;
   assign item_ctl.row_end   = rend;
   assign item_ctl.image_end = iend;

   always_comb begin
      await_in = await_ff;
      first_in = first_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      filt_in  = filt_ff;
      if (take) begin
         if (await_ff) begin
            // latch the row's filter code
            filt_in  = (stream_byte > 8'(FLT_PAETH)) ? FLT_BAD
                     : filter_type'(stream_byte[2:0]);
            await_in = 1'b0;
            col_in   = '0;
         end else if (rend) begin
            col_in   = '0;
            await_in = 1'b1;
            if (iend) begin
               row_in   = '0;
               first_in = 1'b1;
            end else begin
               row_in   = row_next[ROWS_W-1:0];
               first_in = 1'b0;
            end
         end else begin
            col_in = col_next[ADDR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         await_ff <= 1'b1;
         first_ff <= 1'b1;
         col_ff   <= '0;
         row_ff   <= '0;
         filt_ff  <= FLT_NONE;
      end else begin
         await_ff <= await_in;
         first_ff <= first_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         filt_ff  <= filt_in;
      end
   end

endmodule

// ----- hw/rtl/psu_back.sv -----
module psu_back #(
   parameter int MAX_ROW_BYTES   = 8192,
   parameter int MAX_PIXEL_BYTES = 8
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              q_empty,
   input  logic [7:0]                                        q_byte,
   input  logic [((MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1)-1:0] q_col,
   input  psu_pkg::ctl_type                                  q_ctl,
   output logic                                              q_pop,
   input  logic [psu_pkg::BPP_W-1:0]                         eff_bpp,
   input  logic                                              rsp_pop,
   output logic                                              rsp_empty,
   output psu_pkg::rsp_type                                  rsp_word
);
   import psu_pkg::*;

   localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int PIX_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam int CB_W   = (ADDR_W > BPP_W) ? ADDR_W : BPP_W;
   localparam int OCW    = $clog2(OUT_DEPTH + 1);
   localparam int RSP_W  = $bits(rsp_type);

   logic              s1_valid_ff;
   logic [7:0]        s1_byte_ff;
   logic [ADDR_W-1:0] s1_col_ff;
   ctl_type           s1_ctl_ff;
   logic              byp_ff;
   logic [7:0]        byp_data_ff;
   logic [7:0]        left_ff [MAX_PIXEL_BYTES];
   logic [7:0]        up_ff   [MAX_PIXEL_BYTES];

   logic [7:0]        ram_rdata;
   logic [OCW-1:0]    out_count;
   logic              out_full;
   logic [PIX_W-1:0]  hidx;
   logic              has_left;
   logic [7:0]        a, b, c, pred, recon;
   logic [8:0]        avg_sum;
   rsp_type           s1_word;
   logic [RSP_W-1:0]  out_rdata;

   // Hold back the read until the result queue is sure to have room for it, counting the word in the s1 stage.
   assign q_pop = !q_empty && ((OCW + 1)'(out_count) + (OCW + 1)'(s1_valid_ff)
                               < (OCW + 1)'(OUT_DEPTH));

   assign hidx     = PIX_W'(eff_bpp - 1'b1);
   assign has_left = (CB_W'(s1_col_ff) >= CB_W'(eff_bpp));
   assign a        = has_left ? left_ff[hidx] : 8'd0;
   assign b        = s1_ctl_ff.first_row ? 8'd0 : (byp_ff ? byp_data_ff : ram_rdata);
   assign c        = (has_left && !s1_ctl_ff.first_row) ? up_ff[hidx] : 8'd0;
   assign avg_sum  = {1'b0, a} + {1'b0, b};

   always_comb begin
      case (s1_ctl_ff.filter)
         FLT_SUB:   pred = a;
         FLT_UP:    pred = b;
         FLT_AVG:   pred = avg_sum[8:1];
         FLT_PAETH: pred = paeth(a, b, c);
         default:   pred = 8'd0;
      endcase
   end

   assign recon = s1_byte_ff + pred;

   assign s1_word.pixel_byte = recon;
   assign s1_word.row_end    = s1_ctl_ff.row_end;
   assign s1_word.image_end  = s1_ctl_ff.image_end;
   assign s1_word.bad_filter = (s1_ctl_ff.filter == FLT_BAD);

   psu_ram #(
      .WIDTH (8),
      .DEPTH (MAX_ROW_BYTES)
   ) u_prior_row (
      .clock (clock),
      .we    (s1_valid_ff),
      .waddr (s1_col_ff),
      .wdata (recon),
      .re    (q_pop),
      .raddr (q_col),
      .rdata (ram_rdata)
   );

   psu_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (s1_valid_ff),
      .wdata (s1_word),
      .pop   (rsp_pop),
      .rdata (out_rdata),
      .count (out_count),
      .full  (out_full),
      .empty (rsp_empty)
   );

   assign rsp_word = rsp_type'(out_rdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_byte_ff  <= q_byte;
         s1_col_ff   <= q_col;
         s1_ctl_ff   <= q_ctl;
         // forward the byte being written this cycle to a read of the same column
         byp_ff      <= s1_valid_ff && (s1_col_ff == q_col) && !out_full;
         byp_data_ff <= recon;
      end
      if (s1_valid_ff) begin
         left_ff[0] <= recon;
         up_ff[0]   <= b;
         for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
            left_ff[i] <= left_ff[i-1];
            up_ff[i]   <= up_ff[i-1];
         end
      end
   end

endmodule
